/* sv/gbd_pkg.sv */
// Package for the greedy banknote dispenser: field widths, request and status codes,
// controller command bits and datapath status bits. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gbd_pkg;
    localparam int MaxEntriesDef = 16;
    localparam int ValW = 16;
    localparam int CntW = 16;
    localparam int AmtW = 32;
    localparam int MaxRes = 16;

    typedef enum logic [2:0] {
        REQ_APPEND = 3'd0, REQ_WRITE = 3'd1, REQ_SETCNT = 3'd2,
        REQ_REMOVE = 3'd3, REQ_READ = 3'd4, REQ_DISP = 3'd5
    } t_req;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_SHORT = 3'd1;
    localparam logic [2:0] ST_NEG = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_FULL = 3'd4;

    // controller to datapath command bits
    localparam int NumCmd = 8;
    localparam int C_LOAD = 0;   // latch request
    localparam int C_EXEC = 1;   // table op / result
    localparam int C_SCAN = 2;   // step scan pointer
    localparam int C_SCAN0 = 3;  // start scan
    localparam int C_DIV0 = 4;   // start divide
    localparam int C_DIV = 5;    // divide step
    localparam int C_EMIT = 6;   // build dispense result
    localparam int C_SHIFT = 7;  // remove shift step

    // datapath to controller status bits
    localparam int NumSts = 9;
    localparam int SB_PTR_END = 0;     // scan pointer past last entry
    localparam int SB_IS_DISP = 1;     // request is a dispense
    localparam int SB_NO_BEST = 2;     // scan found no denomination
    localparam int SB_DIV_DONE = 3;    // all quotient bits done
    localparam int SB_TAKE_ZERO = 4;   // zero notes of this denomination
    localparam int SB_WALK_DONE = 5;   // paid in full or result limit hit
    localparam int SB_DO_SHIFT = 6;    // matching entry found for removal
    localparam int SB_FIND_REQ = 7;    // request needs a find pass
    localparam int SB_SHIFT_DONE = 8;  // last shift step

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] note_value;
        logic [16:0] note_count;
        logic [3:0]  entry_index;
        logic [31:0] amount;
    } t_req_beat;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] out_value;
        logic [15:0] out_count;
        logic [31:0] remainder;
        logic [4:0]  entry_total;
        logic        last;
    } t_res_beat;
endpackage
`default_nettype wire

/* sv/gbd_if.sv */
// Valid/ready channel interfaces for request and result beats.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface gbd_req_if;
    logic valid;
    logic ready;
    logic [2:0]  req_type;
    logic [15:0] note_value;
    logic signed [16:0] note_count;
    logic [3:0]  entry_index;
    logic [31:0] amount;
    modport source (output valid, req_type, note_value, note_count, entry_index, amount,
                    input ready);
    modport sink (input valid, req_type, note_value, note_count, entry_index, amount,
                  output ready);
endinterface

interface gbd_res_if;
    logic valid;
    logic ready;
    logic [2:0]  status;
    logic [15:0] out_value;
    logic [15:0] out_count;
    logic [31:0] remainder;
    logic [4:0]  entry_total;
    logic        last;
    modport source (output valid, status, out_value, out_count, remainder, entry_total, last,
                    input ready);
    modport sink (input valid, status, out_value, out_count, remainder, entry_total, last,
                  output ready);
endinterface
`default_nettype wire

/* sv/greedy_banknote_dispenser_unit.sv */
// Top level of the greedy banknote dispenser: controller plus datapath.
// Append/write/read pass through the find, exec and out states; set count adds a table
// scan, remove (and set count to zero) also a shift of the entries behind the found slot.
// Dispense: per denomination a scan, a bit-serial divide and an emit step; each beat
// is held until the next is found or the walk ends. One request at a time.
// Reset (synchronous, active low) empties the table; entry contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none
module greedy_banknote_dispenser_unit #(
    parameter int MAX_ENTRIES = gbd_pkg::MaxEntriesDef
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    gbd_req_if.sink   i_req,
    gbd_res_if.source o_res
);
    import gbd_pkg::*;

    logic [NumCmd-1:0] cmd;
    logic [NumSts-1:0] sts;
    t_req_beat req;
    t_res_beat res;

    assign req = '{i_req.req_type, i_req.note_value, i_req.note_count,
                   i_req.entry_index, i_req.amount};
    assign o_res.status = res.status;
    assign o_res.out_value = res.out_value;
    assign o_res.out_count = res.out_count;
    assign o_res.remainder = res.remainder;
    assign o_res.entry_total = res.entry_total;
    assign o_res.last = res.last;

    gbd_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_req.valid), .o_in_ready(i_req.ready),
        .o_out_valid(o_res.valid), .i_out_ready(o_res.ready),
        .i_sts(sts), .o_cmd(cmd)
    );

    gbd_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req),
        .i_cmd(cmd), .o_sts(sts), .o_res(res)
    );
endmodule
`default_nettype wire

/* sv/gbd_datapath.sv */
// Datapath: denomination table, scan unit, bit-serial divider, result register.
// Depends on gbd_pkg; driven by gbd_ctrl through command and status bits.
`timescale 1ns / 1ps
`default_nettype none
module gbd_datapath #(
    parameter int MAX_ENTRIES = gbd_pkg::MaxEntriesDef,
    parameter int IW = $clog2(MAX_ENTRIES),
    parameter int NW = $clog2(MAX_ENTRIES + 1)
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire gbd_pkg::t_req_beat i_req,
    input  wire logic [gbd_pkg::NumCmd-1:0] i_cmd,
    output logic [gbd_pkg::NumSts-1:0] o_sts,
    output gbd_pkg::t_res_beat o_res
);
    import gbd_pkg::*;

    logic [ValW-1:0] r_val [MAX_ENTRIES];
    logic [CntW-1:0] r_cnt [MAX_ENTRIES];
    logic [NW-1:0] r_used;
    t_req_beat r_q;
    logic [IW:0] r_ptr;
    logic [ValW-1:0] r_best;
    logic [ValW:0] r_bound;
    logic [CntW-1:0] r_bcnt;
    logic r_found;
    logic [AmtW-1:0] r_rem, r_quo, r_part;
    logic [5:0] r_dstep;
    logic [4:0] r_k;
    t_res_beat r_res;
    logic [IW:0] r_fpos;

    logic [IW-1:0] ptr_i;
    logic ptr_end;
    logic signed [16:0] sc;
    logic [CntW-1:0] clamped;
    logic idx_ok;
    logic [AmtW:0] trial;
    logic [CntW-1:0] take;
    logic [AmtW-1:0] prod;
    logic shift_more;
    t_res_beat exec_res;

    assign ptr_i = r_ptr[IW-1:0];
    assign ptr_end = (r_ptr >= (IW+1)'(r_used));
    assign sc = signed'(r_q.note_count);
    assign clamped = sc[16] ? '0 : sc[15:0];
    assign idx_ok = (int'(r_q.entry_index) < int'(r_used)) &&
                    (int'(r_q.entry_index) < MAX_ENTRIES);
    assign trial = {r_part, r_rem[AmtW-1 - r_dstep[4:0]]} - {1'b0, 16'd0, r_best};
    assign take = (r_quo > AmtW'(r_bcnt)) ? r_bcnt : r_quo[CntW-1:0];
    assign prod = AmtW'(r_best) * AmtW'(take);
    assign shift_more = (r_fpos + 1'b1 < (IW+1)'(r_used));

    // status to controller
    assign o_sts[SB_PTR_END] = ptr_end;
    assign o_sts[SB_IS_DISP] = (r_q.req_type == REQ_DISP);
    assign o_sts[SB_NO_BEST] = (r_best == '0);
    assign o_sts[SB_DIV_DONE] = (r_dstep == 6'd32);
    assign o_sts[SB_TAKE_ZERO] = (take == '0);
    assign o_sts[SB_WALK_DONE] = (r_rem == '0) || (r_k == 5'(MaxRes));
    assign o_sts[SB_DO_SHIFT] = r_found && (r_q.req_type == REQ_REMOVE ||
                                (r_q.req_type == REQ_SETCNT && sc == 0));
    assign o_sts[SB_FIND_REQ] = (r_q.req_type == REQ_SETCNT) ||
                                (r_q.req_type == REQ_REMOVE);
    assign o_sts[SB_SHIFT_DONE] = !shift_more;
    assign o_res = r_res;

    // result beat of table ops and of the dispense finish
    always_comb begin
        exec_res = '{ST_OK, '0, '0, '0, 5'(r_used), 1'b1};
        case (r_q.req_type)
            REQ_APPEND: begin
                if (r_used >= NW'(MAX_ENTRIES)) begin
                    exec_res.status = ST_FULL;
                end else begin
                    exec_res.entry_total = 5'(r_used + 1'b1);
                end
            end
            REQ_WRITE: begin
                if (!idx_ok) begin
                    exec_res.status = ST_NOTFOUND;
                end
            end
            REQ_SETCNT: begin
                if (sc < 0) begin
                    exec_res.status = ST_NEG;
                end else if (!r_found) begin
                    exec_res.status = ST_NOTFOUND;
                end
            end
            REQ_REMOVE: exec_res.status = ST_NOTFOUND;
            REQ_READ: begin
                if (!idx_ok) begin
                    exec_res.status = ST_NOTFOUND;
                end else begin
                    exec_res.out_value = r_val[IW'(r_q.entry_index)];
                    exec_res.out_count = r_cnt[IW'(r_q.entry_index)];
                end
            end
            REQ_DISP: begin
                // finish: patch status/remainder/last on held or empty beat
                if (r_k != '0) begin
                    exec_res = r_res;
                end
                exec_res.remainder = r_rem;
                exec_res.status = (r_rem != '0) ? ST_SHORT : ST_OK;
                exec_res.last = 1'b1;
            end
            default: ;
        endcase
    end

    // table and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            if (i_cmd[C_LOAD]) begin
                r_q <= i_req;
                r_ptr <= '0;
                r_found <= 1'b0;
                r_k <= '0;
                r_rem <= i_req.amount;
                r_bound <= {1'b1, {ValW{1'b0}}};
                r_best <= '0;
                r_res.last <= 1'b0;
            end
            // find pass for set count / remove, and max scan for dispense
            if (i_cmd[C_SCAN] && !ptr_end) begin
                r_ptr <= r_ptr + 1'b1;
                if (r_q.req_type == REQ_DISP) begin
                    if (r_val[ptr_i] > r_best && {1'b0, r_val[ptr_i]} < r_bound &&
                        r_cnt[ptr_i] != '0) begin
                        r_best <= r_val[ptr_i];
                    end
                end else if (!r_found && r_val[ptr_i] == r_q.note_value) begin
                    r_found <= 1'b1;
                    r_fpos <= r_ptr;
                end
            end
            if (i_cmd[C_SCAN0]) begin
                r_ptr <= '0;
                r_best <= '0;
                r_found <= 1'b0;
            end
            // shift entries down over removed slot
            if (i_cmd[C_SHIFT]) begin
                if (shift_more) begin
                    r_val[r_fpos[IW-1:0]] <= r_val[IW'(r_fpos + 1'b1)];
                    r_cnt[r_fpos[IW-1:0]] <= r_cnt[IW'(r_fpos + 1'b1)];
                    r_fpos <= r_fpos + 1'b1;
                end else begin
                    r_used <= r_used - 1'b1;
                    r_res <= '{ST_OK, '0, '0, '0, 5'(r_used - 1'b1), 1'b1};
                end
            end
            // first-match count for the chosen denomination, found during divide
            if (i_cmd[C_DIV0]) begin
                r_dstep <= '0;
                r_part <= '0;
                r_quo <= '0;
                r_bound <= {1'b0, r_best};
                r_ptr <= '0;
                r_found <= 1'b0;
            end
            if (i_cmd[C_DIV]) begin
                if (r_dstep != 6'd32) begin
                    r_dstep <= r_dstep + 1'b1;
                    if (!trial[AmtW]) begin
                        r_part <= trial[AmtW-1:0];
                        r_quo <= {r_quo[AmtW-2:0], 1'b1};
                    end else begin
                        r_part <= {r_part[AmtW-2:0], r_rem[AmtW-1 - r_dstep[4:0]]};
                        r_quo <= {r_quo[AmtW-2:0], 1'b0};
                    end
                end
                if (!ptr_end) begin
                    r_ptr <= r_ptr + 1'b1;
                    if (!r_found && r_val[ptr_i] == r_best) begin
                        r_found <= 1'b1;
                        r_bcnt <= r_cnt[ptr_i];
                    end
                end
            end
            if (i_cmd[C_EMIT]) begin
                r_rem <= r_rem - prod;
                r_k <= r_k + 1'b1;
                r_res <= '{ST_OK, r_best, take, r_rem - prod, 5'(r_used), 1'b0};
            end
            // table ops and final results
            if (i_cmd[C_EXEC]) begin
                r_res <= exec_res;
                case (r_q.req_type)
                    REQ_APPEND: begin
                        if (r_used < NW'(MAX_ENTRIES)) begin
                            r_val[r_used[IW-1:0]] <= r_q.note_value;
                            r_cnt[r_used[IW-1:0]] <= clamped;
                            r_used <= r_used + 1'b1;
                        end
                    end
                    REQ_WRITE: begin
                        if (idx_ok) begin
                            r_val[IW'(r_q.entry_index)] <= r_q.note_value;
                            r_cnt[IW'(r_q.entry_index)] <= clamped;
                        end
                    end
                    REQ_SETCNT: begin
                        if (sc > 0 && r_found) begin
                            r_cnt[r_fpos[IW-1:0]] <= clamped;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

/* sv/gbd_ctrl.sv */
// Controller state machine sequencing requests, scans, divides and result beats.
// Depends on gbd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gbd_ctrl (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  wire logic i_out_ready,
    input  wire logic [gbd_pkg::NumSts-1:0] i_sts,
    output logic [gbd_pkg::NumCmd-1:0] o_cmd
);
    import gbd_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001, S_FIND = 9'b000000010, S_EXEC = 9'b000000100,
        S_SHIFT = 9'b000001000, S_SCAN = 9'b000010000, S_DIV = 9'b000100000,
        S_EMIT = 9'b001000000, S_HOLD = 9'b010000000, S_OUT = 9'b100000000
    } t_state;

    t_state r_st, n_st;
    logic r_pend, n_pend; // dispense beat waits to learn if it is the last

    // next-state and commands; a held dispense beat goes out once the next one is found
    always_comb begin
        n_st = r_st;
        n_pend = r_pend;
        o_cmd = '0;
        o_in_ready = (r_st == S_IDLE);
        o_out_valid = (r_st == S_OUT) ||
                      (r_st == S_EMIT && r_pend && !i_sts[SB_TAKE_ZERO]);
        case (r_st)
            S_IDLE: if (i_in_valid) begin
                o_cmd[C_LOAD] = 1'b1;
                n_pend = 1'b0;
                n_st = S_FIND;
            end
            S_FIND: begin
                if (i_sts[SB_IS_DISP]) begin
                    o_cmd[C_SCAN0] = 1'b1;
                    n_st = S_SCAN;
                end else if (i_sts[SB_FIND_REQ] && !i_sts[SB_PTR_END]) begin
                    o_cmd[C_SCAN] = 1'b1;
                end else if (i_sts[SB_DO_SHIFT]) begin
                    n_st = S_SHIFT;
                end else begin
                    n_st = S_EXEC;
                end
            end
            S_SHIFT: begin
                o_cmd[C_SHIFT] = 1'b1;
                if (i_sts[SB_SHIFT_DONE]) begin
                    n_st = S_OUT;
                end
            end
            S_EXEC: begin
                o_cmd[C_EXEC] = 1'b1;
                n_st = S_OUT;
            end
            S_SCAN: begin
                if (!i_sts[SB_PTR_END]) begin
                    o_cmd[C_SCAN] = 1'b1;
                end else if (i_sts[SB_NO_BEST]) begin
                    n_st = S_EXEC;
                end else begin
                    o_cmd[C_DIV0] = 1'b1;
                    n_st = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts[SB_DIV_DONE] && i_sts[SB_PTR_END]) begin
                    n_st = S_EMIT;
                end else begin
                    o_cmd[C_DIV] = 1'b1;
                end
            end
            S_EMIT: begin
                if (i_sts[SB_TAKE_ZERO]) begin
                    o_cmd[C_SCAN0] = 1'b1;
                    n_st = S_SCAN;
                end else if (!r_pend || i_out_ready) begin
                    o_cmd[C_EMIT] = 1'b1;
                    n_pend = 1'b1;
                    n_st = S_HOLD;
                end
            end
            S_HOLD: begin
                if (i_sts[SB_WALK_DONE]) begin
                    n_st = S_EXEC;
                end else begin
                    o_cmd[C_SCAN0] = 1'b1;
                    n_st = S_SCAN;
                end
            end
            S_OUT: if (i_out_ready) begin
                n_pend = 1'b0;
                n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_pend <= 1'b0;
        end else begin
            r_st <= n_st;
            r_pend <= n_pend;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_st))
        else $error("state not one-hot");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_in_ready |-> !o_out_valid)
        else $error("accept while result pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready && r_st == S_OUT) |=> o_out_valid)
        else $error("result dropped");
endmodule
`default_nettype wire

/* sim/tb_greedy_banknote_dispenser_unit.sv */
// Testbench for greedy_banknote_dispenser_unit: table requests and greedy payouts checked
// against a scoreboard that predicts them. Depends on gbd_pkg, gbd_if and the unit itself.
`timescale 1ns / 1ps
`default_nettype none

// Mirrors the denomination table and predicts every result beat of each request.
class payout_scoreboard;
    logic [15:0]       table_values[gbd_pkg::MaxEntriesDef];
    logic [15:0]       table_counts[gbd_pkg::MaxEntriesDef];
    int unsigned       entries;
    gbd_pkg::t_res_beat pending[$];
    int                errors;

    function new_reset();
        entries = 0;
        errors  = 0;
        pending.delete();
        return 0;
    endfunction

    function int locate(logic [15:0] v);
        for (int i = 0; i < entries; i++)
            if (table_values[i] == v) return i;
        return -1;
    endfunction

    function logic [2:0] drop_value(logic [15:0] v);
        int p;
        p = locate(v);
        if (p < 0) return gbd_pkg::ST_NOTFOUND;
        for (int i = p; i + 1 < entries; i++) begin
            table_values[i] = table_values[i + 1];
            table_counts[i] = table_counts[i + 1];
        end
        entries--;
        return gbd_pkg::ST_OK;
    endfunction

    function void push_beat(logic [2:0] st, logic [15:0] v, logic [15:0] c,
                            logic [31:0] rem, logic lst);
        gbd_pkg::t_res_beat b;
        b.status      = st;
        b.out_value   = v;
        b.out_count   = c;
        b.remainder   = rem;
        b.entry_total = entries[4:0];
        b.last        = lst;
        pending.insert(pending.size(), b);
    endfunction

    // Greedy payout, largest denomination first; counts are left untouched
    function void predict_payout(logic [31:0] amount);
        logic [31:0] rem;
        logic [16:0] bound;
        logic [15:0] best;
        logic [31:0] n;
        int          p;
        int          k;
        rem   = amount;
        bound = 17'h10000;
        k     = 0;
        while (rem != 0 && k < gbd_pkg::MaxRes) begin
            best = 0;
            for (int i = 0; i < entries; i++)
                if (table_values[i] > best && table_values[i] < bound && table_counts[i] > 0)
                    best = table_values[i];
            if (best == 0) break;
            bound = best;
            p = locate(best);
            n = rem / best;
            if (table_counts[p] < n) n = table_counts[p];
            if (n == 0) continue;
            rem = rem - best * n;
            push_beat(gbd_pkg::ST_OK, best, n[15:0], rem, 1'b0);
            k++;
        end
        if (k == 0) begin
            push_beat(rem != 0 ? gbd_pkg::ST_SHORT : gbd_pkg::ST_OK, 0, 0, rem, 1'b1);
        end else begin
            pending[$].status    = rem != 0 ? gbd_pkg::ST_SHORT : gbd_pkg::ST_OK;
            pending[$].remainder = rem;
            pending[$].last      = 1'b1;
        end
    endfunction

    function void note_request(gbd_pkg::t_req_beat r);
        logic signed [16:0] c;
        logic [15:0]        cl;
        logic [2:0]         st;
        logic [15:0]        rv;
        logic [15:0]        rc;
        int                 p;
        c  = r.note_count;
        cl = (c < 0) ? 16'd0 : c[15:0];
        st = gbd_pkg::ST_OK;
        rv = 0;
        rc = 0;
        case (r.req_type)
            gbd_pkg::REQ_APPEND: begin
                if (entries >= gbd_pkg::MaxEntriesDef) st = gbd_pkg::ST_FULL;
                else begin
                    table_values[entries] = r.note_value;
                    table_counts[entries] = cl;
                    entries++;
                end
            end
            gbd_pkg::REQ_WRITE: begin
                if (r.entry_index >= entries) st = gbd_pkg::ST_NOTFOUND;
                else begin
                    table_values[r.entry_index] = r.note_value;
                    table_counts[r.entry_index] = cl;
                end
            end
            gbd_pkg::REQ_SETCNT: begin
                if (c == 0) st = drop_value(r.note_value);
                else if (c < 0) st = gbd_pkg::ST_NEG;
                else begin
                    p = locate(r.note_value);
                    if (p < 0) st = gbd_pkg::ST_NOTFOUND;
                    else table_counts[p] = cl;
                end
            end
            gbd_pkg::REQ_REMOVE: st = drop_value(r.note_value);
            gbd_pkg::REQ_READ: begin
                if (r.entry_index >= entries) st = gbd_pkg::ST_NOTFOUND;
                else begin
                    rv = table_values[r.entry_index];
                    rc = table_counts[r.entry_index];
                end
            end
            gbd_pkg::REQ_DISP: begin
                predict_payout(r.amount);
                return;
            end
            default: ;
        endcase
        push_beat(st, rv, rc, 0, 1'b1);
    endfunction

    function void check_result(gbd_pkg::t_res_beat got);
        gbd_pkg::t_res_beat exp_b;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result beat %p", $realtime, got);
            errors++;
            return;
        end
        exp_b = pending.pop_front();
        if (exp_b.status !== got.status || exp_b.out_value !== got.out_value ||
            exp_b.out_count !== got.out_count || exp_b.remainder !== got.remainder ||
            exp_b.entry_total !== got.entry_total || exp_b.last !== got.last) begin
            $display("%0t: mismatch expected %p actual %p", $realtime, exp_b, got);
            errors++;
        end
    endfunction
endclass

module tb_greedy_banknote_dispenser_unit;
    import gbd_pkg::*;

    logic i_clk;
    logic i_rst_n;
    gbd_req_if req_ch();
    gbd_res_if res_ch();

    payout_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    int  quiet_cycles;
    int  dummy;

    greedy_banknote_dispenser_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: random stalls, or a long hold-off
    always @(posedge i_clk)
        res_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

    // Result monitor
    always @(posedge i_clk) begin
        gbd_pkg::t_res_beat b;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            b.status      = res_ch.status;
            b.out_value   = res_ch.out_value;
            b.out_count   = res_ch.out_count;
            b.remainder   = res_ch.remainder;
            b.entry_total = res_ch.entry_total;
            b.last        = res_ch.last;
            sb.check_result(b);
        end
    end

    // Watchdog on cycles with no beat on either channel
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 20000) begin
            $display("tb_greedy_banknote_dispenser_unit failed");
            $finish;
        end
    end

    task automatic send_request(input logic [2:0] rt, input logic [15:0] v,
                                input logic signed [16:0] c, input logic [3:0] idx,
                                input logic [31:0] amt);
        gbd_pkg::t_req_beat r;
        int gap;
        r.req_type    = rt;
        r.note_value  = v;
        r.note_count  = c;
        r.entry_index = idx;
        r.amount      = amt;
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= rt;
        req_ch.note_value  <= v;
        req_ch.note_count  <= c;
        req_ch.entry_index <= idx;
        req_ch.amount      <= amt;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_request(r);
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 6);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic random_request();
        int          pick;
        logic [15:0] v;
        logic signed [16:0] c;
        logic [31:0] amt;
        pick = $urandom_range(99);
        v    = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12) * 5);
        c    = ($urandom_range(4) == 0) ? 17'($urandom) : 17'($urandom_range(0, 20));
        amt  = ($urandom_range(4) == 0) ? $urandom : $urandom_range(0, 2000);
        if (pick < 30)      send_request(REQ_APPEND, v, c, 4'($urandom), amt);
        else if (pick < 40) send_request(REQ_WRITE, v, c, 4'($urandom), amt);
        else if (pick < 52) send_request(REQ_SETCNT, v, c, 4'($urandom), amt);
        else if (pick < 60) send_request(REQ_REMOVE, v, c, 4'($urandom), amt);
        else if (pick < 70) send_request(REQ_READ, v, c, 4'($urandom), amt);
        else if (pick < 96) send_request(REQ_DISP, v, c, 4'($urandom), amt);
        else                send_request(3'($urandom_range(6, 7)), v, c, 4'($urandom), amt);
    endtask

    // Long receiver hold-off while requests keep coming
    initial begin
        hold_off = 1'b0;
        wait (send_idle_pct == 65);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        sb = new();
        dummy = sb.new_reset();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n            <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= REQ_APPEND;
        req_ch.note_value  <= '0;
        req_ch.note_count  <= '0;
        req_ch.entry_index <= '0;
        req_ch.amount      <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, clamping, duplicates, errors, payout extremes
        send_request(REQ_READ, 0, 0, 0, 0);
        send_request(REQ_REMOVE, 16'd7, 0, 0, 0);
        send_request(REQ_SETCNT, 16'd7, 17'sd3, 0, 0);
        send_request(REQ_DISP, 0, 0, 0, 32'd123);
        send_request(REQ_APPEND, 16'd0, 17'sd5, 0, 0);
        send_request(REQ_APPEND, 16'd100, -17'sd65536, 0, 0);
        send_request(REQ_APPEND, 16'd50, 17'sd65535, 0, 0);
        send_request(REQ_APPEND, 16'd65535, 17'sd2, 0, 0);
        send_request(REQ_APPEND, 16'd20, 17'sd3, 0, 0);
        send_request(REQ_APPEND, 16'd50, 17'sd7, 0, 0);
        send_request(REQ_DISP, 0, 0, 0, 32'd370);
        send_request(REQ_WRITE, 16'd100, 17'sd10, 4'd1, 0);
        send_request(REQ_WRITE, 16'd9, 17'sd1, 4'd15, 0);
        send_request(REQ_READ, 0, 0, 4'd2, 0);
        send_request(REQ_SETCNT, 16'd20, -17'sd1, 0, 0);
        send_request(REQ_SETCNT, 16'd20, 17'sd0, 0, 0);
        send_request(REQ_SETCNT, 16'd50, 17'sd4, 0, 0);
        send_request(REQ_DISP, 0, 0, 0, 32'd0);
        send_request(REQ_DISP, 0, 0, 0, 32'hFFFF_FFFF);
        send_request(REQ_REMOVE, 16'd65535, 0, 0, 0);
        send_request(3'd6, 16'hFFFF, -17'sd1, 4'hF, 32'hFFFF_FFFF);
        send_request(3'd7, 0, 0, 0, 0);
        // fill the table, then one append too many
        while (sb.entries < MaxEntriesDef)
            send_request(REQ_APPEND, 16'($urandom_range(1, 40) * 5), 17'($urandom_range(1, 9)),
                         0, 0);
        send_request(REQ_APPEND, 16'd1, 17'sd1, 0, 0);
        send_request(REQ_DISP, 0, 0, 0, 32'hFFFF_FFFF);

        // Random: four idle/stall phases
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 65 : 34) : 0;
            recv_stall_pct = (ph == 2) ? 65 : (ph == 3 ? 34 : 0);
            repeat (16) random_request();
        end
        req_ch.valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb_greedy_banknote_dispenser_unit passed");
        else
            $display("tb_greedy_banknote_dispenser_unit failed");
        $finish;
    end
endmodule
`default_nettype wire

/* greedy_banknote_dispenser_unit.f */
sv/gbd_pkg.sv
sv/gbd_if.sv
sv/gbd_datapath.sv
sv/gbd_ctrl.sv
sv/greedy_banknote_dispenser_unit.sv
sim/tb_greedy_banknote_dispenser_unit.sv
